// File: hdl/lzf_pkg.sv
// Shared types and constants for the LZF decompressor.
package lzf_pkg;

  localparam logic [7:0] CTRL_LIT_LIMIT = 8'h20;
  localparam int LEN_W = 9;
  localparam int DIST_W = 14;
  localparam logic [DIST_W-1:0] MAX_DIST = 14'd8192;
  localparam logic [2:0] LEN_EXTENDED = 3'd7;
  localparam logic [LEN_W-1:0] LEN_BIAS = 9'd2;
  localparam logic [LEN_W-1:0] EXT_BIAS = 9'd9;

  typedef struct packed {
    logic              is_copy;
    logic [7:0]        lit;
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] distance;
    logic              done;
  } cmd_t;

endpackage

// File: hdl/lzf_ram.sv
// Generic simple dual-port RAM with registered read.
module lzf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/lzf_cmd_fifo.sv
// Four-entry command queue between token parser and copy engine.
module lzf_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lzf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output lzf_pkg::cmd_t head
);

  lzf_pkg::cmd_t slots [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;

  assign full  = (count == 3'd4);
  assign empty = (count == 3'd0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 2'd1;
      end
      if (pop && !empty) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + 3'((push && !full) ? 1 : 0) - 3'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

// File: hdl/lzf_front.sv
// Token parser: classifies stream bytes, tracks frame length, issues commands.
module lzf_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic [31:0]   out_length,
  output logic          cmd_push,
  output lzf_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    PH_CTRL = 4'b0001,
    PH_LIT  = 4'b0010,
    PH_EXT  = 4'b0100,
    PH_DIST = 4'b1000
  } phase_t;

  phase_t phase;
  logic [4:0] lit_left;
  logic [lzf_pkg::LEN_W-1:0] mlen;
  logic [4:0] dhigh;
  logic [31:0] count;

  logic [31:0] left;
  logic lit_done;
  logic copy_done;
  logic [lzf_pkg::LEN_W-1:0] copy_len;
  logic [lzf_pkg::DIST_W-1:0] distance;

  assign left      = out_length - count;
  assign lit_done  = (left == 32'd1);
  assign copy_done = (left != 32'd0) && (32'(mlen) >= left);
  assign copy_len  = copy_done ? left[lzf_pkg::LEN_W-1:0] : mlen;
  assign distance  = lzf_pkg::DIST_W'({dhigh, in_byte}) + lzf_pkg::DIST_W'(1);

  always_comb begin
    cmd = '0;
    cmd_push = 1'b0;
    if (in_valid && phase == PH_LIT) begin
      cmd_push = 1'b1;
      cmd.lit  = in_byte;
      cmd.done = lit_done;
    end else if (in_valid && phase == PH_DIST) begin
      cmd_push     = 1'b1;
      cmd.is_copy  = 1'b1;
      cmd.len      = copy_len;
      cmd.distance = distance;
      cmd.done     = copy_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_CTRL;
      lit_left <= '0;
      mlen     <= '0;
      dhigh    <= '0;
      count    <= '0;
    end else if (in_valid) begin
      unique case (phase)
        PH_CTRL: begin
          if (in_byte < lzf_pkg::CTRL_LIT_LIMIT) begin
            lit_left <= in_byte[4:0];
            phase    <= PH_LIT;
          end else begin
            dhigh <= in_byte[4:0];
            if (in_byte[7:5] == lzf_pkg::LEN_EXTENDED) begin
              phase <= PH_EXT;
            end else begin
              mlen  <= lzf_pkg::LEN_W'(in_byte[7:5]) + lzf_pkg::LEN_BIAS;
              phase <= PH_DIST;
            end
          end
        end
        PH_EXT: begin
          mlen  <= lzf_pkg::LEN_W'(in_byte) + lzf_pkg::EXT_BIAS;
          phase <= PH_DIST;
        end
        PH_LIT: begin
          if (lit_done) begin
            phase    <= PH_CTRL;
            lit_left <= '0;
            mlen     <= '0;
            dhigh    <= '0;
            count    <= '0;
          end else begin
            count <= count + 32'd1;
            if (lit_left == 5'd0) begin
              phase <= PH_CTRL;
            end else begin
              lit_left <= lit_left - 5'd1;
            end
          end
        end
        PH_DIST: begin
          phase <= PH_CTRL;
          mlen  <= '0;
          if (copy_done) begin
            lit_left <= '0;
            dhigh    <= '0;
            count    <= '0;
          end else begin
            count <= count + 32'(mlen);
          end
        end
        default: phase <= PH_CTRL;
      endcase
    end
  end

endmodule

// File: hdl/lzf_back.sv
// Copy engine: writes history, expands back-references, packs output words.
module lzf_back #(
  parameter int WINDOW_BYTES = 8192
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_empty,
  input  lzf_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          pop,
  output logic          empty,
  output logic [63:0]   out_bytes,
  output logic [3:0]    byte_count,
  output logic          run_last,
  output logic          frame_done,
  output logic          bad_distance
);

  localparam int AW = $clog2(WINDOW_BYTES);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t state;
  logic [AW-1:0] wpos;
  logic [lzf_pkg::DIST_W-1:0] fill;
  logic [lzf_pkg::DIST_W-1:0] distance;
  logic [lzf_pkg::LEN_W-1:0] rem;
  logic done;
  logic bad_byte;
  logic bad_acc;
  logic [63:0] acc;
  logic [3:0] cnt;
  logic o_valid;

  logic out_free;
  logic [AW:0] back_addr;
  logic [AW-1:0] raddr;
  logic [7:0] rdata;
  logic [7:0] v;
  logic [3:0] cnt_next;
  logic [63:0] acc_next;
  logic emit;
  logic take;
  logic word_load;
  logic we;
  logic [7:0] wdata;

  assign out_free  = !o_valid || pop;
  assign back_addr = {1'b0, wpos} - (AW+1)'(distance);
  assign raddr     = back_addr[AW-1:0];
  assign v         = bad_byte ? 8'd0 : rdata;
  assign cnt_next  = cnt + 4'd1;
  assign acc_next  = acc | (64'(v) << {cnt[2:0], 3'b000});
  assign emit      = (cnt_next == 4'd8) || (rem == lzf_pkg::LEN_W'(1));
  assign take      = (state == S_IDLE) && !cmd_empty && (cmd.is_copy || out_free);
  assign cmd_pop   = take;
  assign empty     = !o_valid;
  assign word_load = (take && !cmd.is_copy) || (state == S_WRITE && emit && out_free);

  always_comb begin
    we = 1'b0;
    wdata = v;
    if (take && !cmd.is_copy) begin
      we = 1'b1;
      wdata = cmd.lit;
    end else if (state == S_WRITE && (!emit || out_free)) begin
      we = 1'b1;
    end
  end

  lzf_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (wpos),
    .wdata (wdata),
    .re    (state == S_READ),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      bad_byte <= (distance > fill);
    end
    if (take && cmd.is_copy) begin
      distance <= cmd.distance;
    end
    if (take && !cmd.is_copy) begin
      out_bytes    <= 64'(cmd.lit);
      byte_count   <= 4'd1;
      run_last     <= 1'b1;
      frame_done   <= cmd.done;
      bad_distance <= 1'b0;
    end else if (state == S_WRITE && emit && out_free) begin
      out_bytes    <= acc_next;
      byte_count   <= cnt_next;
      run_last     <= (rem == lzf_pkg::LEN_W'(1));
      frame_done   <= done && (rem == lzf_pkg::LEN_W'(1));
      bad_distance <= bad_acc || bad_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wpos    <= '0;
      fill    <= '0;
      rem     <= '0;
      done    <= 1'b0;
      bad_acc <= 1'b0;
      acc     <= '0;
      cnt     <= '0;
      o_valid <= 1'b0;
    end else begin
      if (word_load) begin
        o_valid <= 1'b1;
      end else if (pop) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (cmd.is_copy) begin
              rem   <= cmd.len;
              done  <= cmd.done;
              state <= S_READ;
            end else begin
              if (cmd.done) begin
                wpos <= '0;
                fill <= '0;
              end else begin
                wpos <= wpos + AW'(1);
                fill <= (fill == lzf_pkg::MAX_DIST) ? fill : fill + lzf_pkg::DIST_W'(1);
              end
            end
          end
        end
        S_READ: state <= S_WRITE;
        S_WRITE: begin
          if (!emit || out_free) begin
            rem <= rem - lzf_pkg::LEN_W'(1);
            if (emit) begin
              acc     <= '0;
              cnt     <= '0;
              bad_acc <= 1'b0;
            end else begin
              acc     <= acc_next;
              cnt     <= cnt_next;
              bad_acc <= bad_acc || bad_byte;
            end
            if (rem == lzf_pkg::LEN_W'(1) && done) begin
              wpos <= '0;
              fill <= '0;
            end else begin
              wpos <= wpos + AW'(1);
              fill <= (fill == lzf_pkg::MAX_DIST) ? fill : fill + lzf_pkg::DIST_W'(1);
            end
            if (rem == lzf_pkg::LEN_W'(1)) begin
              state <= S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/lzf_decompress_top.sv
// Top level of the LZF decompressor.
//
// Feed the compressed stream one byte per word through push/full; decoded
// data comes back as words of up to eight bytes through empty/pop. The token
// parser takes one input byte per cycle while its four-entry command queue
// has room; control and length bytes produce no output. The copy engine
// writes a literal byte to history and to the output word together, and
// expands each copied byte as a history RAM read, then a write and pack, so
// a long back-reference keeps the engine busy and input stalls once the queue
// fills behind it. Write out_length over the cfg channel (always ready) only
// while the block is idle; 0 means 2^32 bytes. After the word marked
// frame_done the block starts a fresh frame. Back-references that reach
// before the frame start read zeros and flag bad_distance. History needs no
// clearing pass after reset.
module lzf_decompress_top #(
  parameter int WINDOW_BYTES = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_bytes,
  output logic [3:0]  byte_count,
  output logic        run_last,
  output logic        frame_done,
  output logic        bad_distance,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic [31:0]   out_length;
  logic          in_valid;
  logic          cmd_push;
  lzf_pkg::cmd_t cmd_in;
  lzf_pkg::cmd_t cmd_head;
  logic          cmd_empty;
  logic          cmd_pop;

  // Accept config at any time; the user keeps writes to idle periods.
  assign cfg_ready = 1'b1;
  assign in_valid  = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_length <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      out_length <= cfg_data;
    end
  end

  // Parse tokens and trim copies at the frame end.
  lzf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .out_length (out_length),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  // Decouple parsing from copy expansion.
  lzf_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .full     (full),
    .pop      (cmd_pop),
    .empty    (cmd_empty),
    .head     (cmd_head)
  );

  // Expand commands against history and hold the result word.
  lzf_back #(.WINDOW_BYTES(WINDOW_BYTES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_empty    (cmd_empty),
    .cmd          (cmd_head),
    .cmd_pop      (cmd_pop),
    .pop          (pop),
    .empty        (empty),
    .out_bytes    (out_bytes),
    .byte_count   (byte_count),
    .run_last     (run_last),
    .frame_done   (frame_done),
    .bad_distance (bad_distance)
  );

`ifndef SYNTHESIS
  // Only the final word of a run may be short.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !run_last) |-> (byte_count == 4'd8))
    else $error("short word before end of run");

  // Frame end always closes the run.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_done) |-> run_last)
    else $error("frame_done without run_last");

  // Word size stays within one to eight bytes.
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (byte_count != 4'd0 && byte_count <= 4'd8))
    else $error("byte_count out of range");
`endif

endmodule
